@@ rtl/core/oale_pkg.sv @@
// ----------------------------------------------------------------------------
// oale_pkg: shared definitions for the ordered array list engine
// Command and status codes, cell control bundle, scan and result types.
// ----------------------------------------------------------------------------
package oale_pkg;

  // default store depth
  localparam int unsigned ListCapacityDef = 128;

  // command codes
  localparam logic [3:0] CMD_GET    = 4'd0;
  localparam logic [3:0] CMD_INSERT = 4'd1;
  localparam logic [3:0] CMD_DELETE = 4'd2;
  localparam logic [3:0] CMD_LOCATE = 4'd3;
  localparam logic [3:0] CMD_PUSHF  = 4'd4;
  localparam logic [3:0] CMD_POPF   = 4'd5;
  localparam logic [3:0] CMD_PUSHB  = 4'd6;
  localparam logic [3:0] CMD_POPB   = 4'd7;
  localparam logic [3:0] CMD_CLEAR  = 4'd8;

  // status codes
  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_BADPOS   = 3'd1;
  localparam logic [2:0] STAT_FULL     = 3'd2;
  localparam logic [2:0] STAT_EMPTY    = 3'd3;
  localparam logic [2:0] STAT_NOTFOUND = 3'd4;

  // control broadcast to every cell
  typedef struct packed {
    logic               ins;     // open a slot at the target, tail moves up
    logic               del;     // close the slot at the target, tail moves down
    logic               load;    // snapshot entries into the scan column
    logic               shift;   // move the scan column one cell toward the head
    logic               locate;  // scan hit is a value match, not the target
    logic signed [31:0] value;
  } cell_ctrl_t;

  // one stage of the scan column
  typedef struct packed {
    logic signed [31:0] data;
    logic               hit;
  } scan_t;

  // result item held in the output register
  typedef struct packed {
    logic signed [31:0] read_value;
    logic [7:0]         found_position;
    logic [7:0]         element_count_out;
    logic               is_empty;
    logic [2:0]         status;
  } result_t;

endpackage

@@ rtl/core/oale_in_if.sv @@
// ----------------------------------------------------------------------------
// oale_in_if: command channel
// Valid/ready channel carrying one list command item.
// ----------------------------------------------------------------------------
interface oale_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         command;
  logic [7:0]         position;
  logic signed [31:0] value;

  modport source (output valid, output command, output position, output value,
                  input ready);
  modport sink   (input valid, input command, input position, input value,
                  output ready);
endinterface

@@ rtl/core/oale_out_if.sv @@
// ----------------------------------------------------------------------------
// oale_out_if: result channel
// Valid/ready channel carrying one result item per command.
// ----------------------------------------------------------------------------
interface oale_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] read_value;
  logic [7:0]         found_position;
  logic [7:0]         element_count_out;
  logic               is_empty;
  logic [2:0]         status;

  modport source (output valid, output read_value, output found_position,
                  output element_count_out, output is_empty, output status,
                  input ready);
  modport sink   (input valid, input read_value, input found_position,
                  input element_count_out, input is_empty, input status,
                  output ready);
endinterface

@@ rtl/core/oale_cell.sv @@
// ----------------------------------------------------------------------------
// oale_cell: one list slot
// Holds one entry, moves it up or down with its neighbors, and carries one
// stage of the scan column that drains toward the head.
// ----------------------------------------------------------------------------
module oale_cell #(
  parameter int unsigned IdxW = 7,
  parameter int unsigned Idx  = 0
) (
  input  logic                    clk_i,
  input  oale_pkg::cell_ctrl_t    ctrl_i,
  input  logic [IdxW-1:0]         tgt_i,
  input  logic signed [31:0]      left_data_i,
  input  logic signed [31:0]      right_data_i,
  input  oale_pkg::scan_t         right_scan_i,
  output logic signed [31:0]      data_o,
  output oale_pkg::scan_t         scan_o
);

  localparam logic [IdxW-1:0] MyIdx = IdxW'(Idx);

  logic signed [31:0] data_d, data_q;
  oale_pkg::scan_t    scan_d, scan_q;
  logic               at_tgt, above_tgt;

  assign at_tgt    = (MyIdx == tgt_i);
  assign above_tgt = (MyIdx > tgt_i);

  // entry update: insert opens the target slot, delete pulls the tail down
  always_comb begin
    data_d = data_q;
    if (ctrl_i.ins) begin
      if (at_tgt) begin
        data_d = ctrl_i.value;
      end else if (above_tgt) begin
        data_d = left_data_i;
      end
    end else if (ctrl_i.del) begin
      if (at_tgt || above_tgt) begin
        data_d = right_data_i;
      end
    end
  end

  // scan stage: snapshot with hit flag, then drain toward the head
  always_comb begin
    scan_d = scan_q;
    if (ctrl_i.load) begin
      scan_d.data = data_q;
      scan_d.hit  = ctrl_i.locate ? (data_q == ctrl_i.value) : at_tgt;
    end else if (ctrl_i.shift) begin
      scan_d = right_scan_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    scan_q <= scan_d;
  end

  assign data_o = data_q;
  assign scan_o = scan_q;

endmodule

@@ rtl/core/ordered_array_list_engine_core.sv @@
// ----------------------------------------------------------------------------
// ordered_array_list_engine_core: ordered list of signed words in a cell chain
// Get, insert, delete, locate, push/pop front/back and clear on a list whose
// positions count from 1; every command returns one result item.
// ----------------------------------------------------------------------------
//  channel | dir | handshake    | payload
//  in_i    | in  | valid/ready  | command, position, value
//  out_o   | out | valid/ready  | read_value, found_position,
//          |     |              | element_count_out, is_empty, status
//
//  insert, push, clear and refused commands: no scan, result registered
//  get, delete, pop: scan runs until the target entry reaches the head cell
//  locate: scan runs until the first match reaches the head, or over the list when absent
//  the scan column drains one cell per cycle toward the head cell
//  a command is taken while idle and the result register is free or being
//  taken; reset clears the length, entries are undefined until written
// ----------------------------------------------------------------------------
module ordered_array_list_engine_core #(
  parameter int unsigned LIST_CAPACITY = oale_pkg::ListCapacityDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  oale_in_if.sink    in_i,
  oale_out_if.source out_o
);

  localparam int unsigned IdxW = $clog2(LIST_CAPACITY);
  localparam int unsigned CntW = $clog2(LIST_CAPACITY + 1);
  localparam int unsigned WideW = ((CntW > 8) ? CntW : 8) + 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;

  logic [1:0]            state_d, state_q;
  logic [CntW-1:0]       cnt_d, cnt_q;
  logic                  out_valid_d, out_valid_q;
  oale_pkg::result_t     res_d, res_q;
  logic [IdxW-1:0]       ctr_d, ctr_q;
  logic [IdxW-1:0]       limit_d, limit_q;
  logic                  loc_d, loc_q;

  logic                  accept;
  logic [2:0]            dec_st;
  logic [CntW-1:0]       dec_cnt;
  logic [WideW-1:0]      dec_cnt_w;
  logic                  dec_ins, dec_del, dec_scan, dec_loc;
  logic [IdxW-1:0]       dec_tgt;
  logic [WideW-1:0]      cnt_w, pos_w, cap_w, found_w;
  logic                  scan_done;

  oale_pkg::cell_ctrl_t  ctrl;
  logic signed [31:0]    ent [LIST_CAPACITY];
  oale_pkg::scan_t       scan [LIST_CAPACITY];

  assign cnt_w = WideW'(cnt_q);
  assign pos_w = WideW'(in_i.position);
  assign cap_w = WideW'(LIST_CAPACITY);

  assign in_i.ready = (state_q == ST_IDLE) && (!out_valid_q || out_o.ready);
  assign accept     = in_i.valid && in_i.ready;

  // command decode against the current length
  always_comb begin
    dec_st   = oale_pkg::STAT_OK;
    dec_cnt  = cnt_q;
    dec_ins  = 1'b0;
    dec_del  = 1'b0;
    dec_scan = 1'b0;
    dec_loc  = 1'b0;
    dec_tgt  = IdxW'(pos_w - WideW'(1));
    unique case (in_i.command)
      oale_pkg::CMD_GET: begin
        if (cnt_w == '0) begin
          dec_st = oale_pkg::STAT_EMPTY;
        end else if (pos_w == '0 || pos_w > cnt_w) begin
          dec_st = oale_pkg::STAT_BADPOS;
        end else begin
          dec_scan = 1'b1;
        end
      end
      oale_pkg::CMD_INSERT: begin
        if (pos_w == '0 || pos_w > cnt_w + WideW'(1)) begin
          dec_st = oale_pkg::STAT_BADPOS;
        end else if (cnt_w >= cap_w) begin
          dec_st = oale_pkg::STAT_FULL;
        end else begin
          dec_ins = 1'b1;
          dec_cnt = cnt_q + CntW'(1);
        end
      end
      oale_pkg::CMD_DELETE: begin
        if (cnt_w == '0) begin
          dec_st = oale_pkg::STAT_EMPTY;
        end else if (pos_w == '0 || pos_w > cnt_w) begin
          dec_st = oale_pkg::STAT_BADPOS;
        end else begin
          dec_scan = 1'b1;
          dec_del  = 1'b1;
          dec_cnt  = cnt_q - CntW'(1);
        end
      end
      oale_pkg::CMD_LOCATE: begin
        if (cnt_w == '0) begin
          dec_st = oale_pkg::STAT_NOTFOUND;
        end else begin
          dec_scan = 1'b1;
          dec_loc  = 1'b1;
        end
      end
      oale_pkg::CMD_PUSHF: begin
        dec_tgt = '0;
        if (cnt_w >= cap_w) begin
          dec_st = oale_pkg::STAT_FULL;
        end else begin
          dec_ins = 1'b1;
          dec_cnt = cnt_q + CntW'(1);
        end
      end
      oale_pkg::CMD_POPF: begin
        dec_tgt = '0;
        if (cnt_w == '0) begin
          dec_st = oale_pkg::STAT_EMPTY;
        end else begin
          dec_scan = 1'b1;
          dec_del  = 1'b1;
          dec_cnt  = cnt_q - CntW'(1);
        end
      end
      oale_pkg::CMD_PUSHB: begin
        dec_tgt = IdxW'(cnt_w);
        if (cnt_w >= cap_w) begin
          dec_st = oale_pkg::STAT_FULL;
        end else begin
          dec_ins = 1'b1;
          dec_cnt = cnt_q + CntW'(1);
        end
      end
      oale_pkg::CMD_POPB: begin
        dec_tgt = IdxW'(cnt_w - WideW'(1));
        if (cnt_w == '0) begin
          dec_st = oale_pkg::STAT_EMPTY;
        end else begin
          dec_scan = 1'b1;
          dec_cnt  = cnt_q - CntW'(1);
        end
      end
      oale_pkg::CMD_CLEAR: begin
        dec_cnt = '0;
      end
      default: begin
      end
    endcase
  end

  assign dec_cnt_w = WideW'(dec_cnt);

  // scan is over on a hit in the head cell or when the counter reaches the limit
  assign scan_done = scan[0].hit || (ctr_q == limit_q);
  assign found_w   = WideW'(ctr_q) + WideW'(1);

  // control broadcast to the chain
  always_comb begin
    ctrl.ins    = accept && dec_ins;
    ctrl.del    = accept && dec_del;
    ctrl.load   = accept && dec_scan;
    ctrl.shift  = (state_q == ST_SCAN) && !scan_done;
    ctrl.locate = dec_loc;
    ctrl.value  = in_i.value;
  end

  // sequencer and result register
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    res_d       = res_q;
    ctr_d       = ctr_q;
    limit_d     = limit_q;
    loc_d       = loc_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cnt_d                   = dec_cnt;
          res_d.read_value        = '0;
          res_d.found_position    = '0;
          res_d.element_count_out = dec_cnt_w[7:0];
          res_d.is_empty          = (dec_cnt == '0);
          res_d.status            = dec_st;
          ctr_d                   = '0;
          limit_d                 = IdxW'(cnt_w - WideW'(1));
          loc_d                   = dec_loc;
          if (dec_scan) begin
            state_d = ST_SCAN;
          end else begin
            out_valid_d = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
          if (loc_q) begin
            if (scan[0].hit) begin
              res_d.found_position = found_w[7:0];
              res_d.status         = oale_pkg::STAT_OK;
            end else begin
              res_d.status = oale_pkg::STAT_NOTFOUND;
            end
          end else begin
            res_d.read_value = scan[0].data;
          end
        end else begin
          ctr_d = ctr_q + IdxW'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q   <= res_d;
    ctr_q   <= ctr_d;
    limit_q <= limit_d;
    loc_q   <= loc_d;
  end

  // row of cells, each linked to its neighbors; the end cells see zeros outside
  for (genvar k = 0; k < LIST_CAPACITY; k++) begin : g_cell
    logic signed [31:0] left_data, right_data;
    oale_pkg::scan_t    right_scan;

    if (k == 0) begin : g_head
      assign left_data = '0;
    end else begin : g_mid
      assign left_data = ent[k-1];
    end
    if (k == LIST_CAPACITY - 1) begin : g_tail
      assign right_data = '0;
      assign right_scan = '0;
    end else begin : g_body
      assign right_data = ent[k+1];
      assign right_scan = scan[k+1];
    end

    oale_cell #(
      .IdxW (IdxW),
      .Idx  (k)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .tgt_i        (dec_tgt),
      .left_data_i  (left_data),
      .right_data_i (right_data),
      .right_scan_i (right_scan),
      .data_o       (ent[k]),
      .scan_o       (scan[k])
    );
  end

  // result port
  assign out_o.valid             = out_valid_q;
  assign out_o.read_value        = res_q.read_value;
  assign out_o.found_position    = res_q.found_position;
  assign out_o.element_count_out = res_q.element_count_out;
  assign out_o.is_empty          = res_q.is_empty;
  assign out_o.status            = res_q.status;

  // length never passes the store depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    WideW'(cnt_q) <= cap_w)
    else $error("list length above capacity");

  // a scan starts only with the result register empty, and it stays so
  a_scan_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> !out_valid_q)
    else $error("result register busy during scan");

  // a positional read always hits before the scan limit is passed
  a_tgt_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && !loc_q && ctr_q == limit_q) |-> scan[0].hit)
    else $error("positional scan ran past its limit");

  // a command that needs no scan produces a result at once, with the engine idle
  a_scan_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !dec_scan) |=> (out_valid_q && state_q == ST_IDLE))
    else $error("immediate result not delivered");

endmodule
